// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sspr_pkg.sv -----
// ---------------------------------------------------------------------------
// sspr_pkg
// Types, constants and tables of the split-step phase rotation unit.
// ---------------------------------------------------------------------------
`default_nettype none

package sspr_pkg;

	localparam int GRID          = 64;
	localparam int CORDIC_STAGES = 24;

	// Arithmetic right shift of drift results: 3 * floor(log2(GRID)).
	localparam int GRID_SHIFT = 3 * ($clog2(GRID + 1) - 1);

	localparam int IDX_W      = 6;
	localparam int WN_W       = 8;   // wrapped wavenumber, |n| <= 32
	localparam int KSQ_W      = 14;  // sum of three squares, <= 3072
	localparam int CELL_IDX_W = 5;   // up to 32 rotation cells
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KICK  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT = CFG_IDX_W'(1);

	// Limit gain of the rotation, Q1.30.
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

	typedef struct packed {
		logic               valid;
		logic               mode;
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic [1:0]         quad;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} cordic_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] re;
		logic signed [31:0] im;
	} result_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic signed [31:0] atan_turn(input logic [CELL_IDX_W-1:0] i);
		logic signed [31:0] a;
		case (i)
			5'd0:    a = 32'sd536870912;
			5'd1:    a = 32'sd316933406;
			5'd2:    a = 32'sd167458907;
			5'd3:    a = 32'sd85004756;
			5'd4:    a = 32'sd42667331;
			5'd5:    a = 32'sd21354465;
			5'd6:    a = 32'sd10679838;
			5'd7:    a = 32'sd5340245;
			5'd8:    a = 32'sd2670163;
			5'd9:    a = 32'sd1335087;
			5'd10:   a = 32'sd667544;
			5'd11:   a = 32'sd333772;
			5'd12:   a = 32'sd166886;
			5'd13:   a = 32'sd83443;
			5'd14:   a = 32'sd41722;
			5'd15:   a = 32'sd20861;
			5'd16:   a = 32'sd10430;
			5'd17:   a = 32'sd5215;
			5'd18:   a = 32'sd2608;
			5'd19:   a = 32'sd1304;
			5'd20:   a = 32'sd652;
			5'd21:   a = 32'sd326;
			5'd22:   a = 32'sd163;
			5'd23:   a = 32'sd81;
			5'd24:   a = 32'sd41;
			5'd25:   a = 32'sd20;
			5'd26:   a = 32'sd10;
			5'd27:   a = 32'sd5;
			5'd28:   a = 32'sd3;
			5'd29:   a = 32'sd1;
			5'd30:   a = 32'sd1;
			default: a = 32'sd0;
		endcase
		return a;
	endfunction

	// Wrap a grid index to a signed wavenumber.
	function automatic logic signed [WN_W-1:0] wavenumber(input logic [IDX_W-1:0] idx);
		int v;
		v = int'(idx);
		if (v >= GRID / 2)
			v = v - GRID;
		return WN_W'(v);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/sspr_phase.sv -----
// ---------------------------------------------------------------------------
// sspr_phase
// Front end: registers a request, forms the phase angle and splits it into
// a quadrant and a residual angle for the rotation cells.
// ---------------------------------------------------------------------------
`default_nettype none

module sspr_phase (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           load,
	input  wire logic                           mode,
	input  wire logic signed [31:0]             re_in,
	input  wire logic signed [31:0]             im_in,
	input  wire logic signed [31:0]             potential,
	input  wire logic [sspr_pkg::IDX_W-1:0]     idx_i,
	input  wire logic [sspr_pkg::IDX_W-1:0]     idx_j,
	input  wire logic [sspr_pkg::IDX_W-1:0]     idx_k,
	input  wire logic [31:0]                    kick_coeff,
	input  wire logic [31:0]                    drift_coeff,
	output sspr_pkg::cordic_t                   head
);

	logic signed [sspr_pkg::WN_W-1:0] wn_i, wn_j, wn_k;
	logic signed [15:0]               sq_i, sq_j, sq_k;
	logic [sspr_pkg::KSQ_W-1:0]       ksq_c;

	logic                             valid_s1, mode_s1;
	logic signed [31:0]               re_s1, im_s1, pot_s1;
	logic [sspr_pkg::KSQ_W-1:0]       ksq_s1;

	logic signed [32:0]               op_a, op_b;
	logic signed [65:0]               prod_c;
	logic                             valid_s2, mode_s2;
	logic signed [31:0]               re_s2, im_s2;
	logic [63:0]                      prod_s2;

	logic [63:0]                      neg_c;
	logic [31:0]                      phase_c;
	logic                             valid_s3, mode_s3;
	logic signed [31:0]               re_s3, im_s3, z_s3;
	logic [1:0]                       quad_s3;

	always_comb begin
		wn_i  = sspr_pkg::wavenumber(idx_i);
		wn_j  = sspr_pkg::wavenumber(idx_j);
		wn_k  = sspr_pkg::wavenumber(idx_k);
		sq_i  = 16'(wn_i * wn_i);
		sq_j  = 16'(wn_j * wn_j);
		sq_k  = 16'(wn_k * wn_k);
		ksq_c = sspr_pkg::KSQ_W'(sq_i + sq_j + sq_k);
	end

	// One shared multiplier: unsigned coefficient times potential or kSq.
	always_comb begin
		op_a   = $signed({1'b0, (mode_s1 ? drift_coeff : kick_coeff)});
		op_b   = mode_s1 ? $signed({(33 - sspr_pkg::KSQ_W)'(0), ksq_s1})
		                 : $signed({pot_s1[31], pot_s1});
		prod_c = op_a * op_b;
	end

	// Negate, pick the phase bits; nearest quarter turn is phase[31:30] + phase[29].
	always_comb begin
		neg_c   = 64'(0) - prod_s2;
		phase_c = mode_s2 ? neg_c[31:0] : neg_c[47:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= load;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			re_s1   <= re_in;
			im_s1   <= im_in;
			pot_s1  <= potential;
			ksq_s1  <= ksq_c;

			mode_s2 <= mode_s1;
			re_s2   <= re_s1;
			im_s2   <= im_s1;
			prod_s2 <= prod_c[63:0];

			mode_s3 <= mode_s2;
			re_s3   <= re_s2;
			im_s3   <= im_s2;
			quad_s3 <= phase_c[31:30] + {1'b0, phase_c[29]};
			z_s3    <= {{2{phase_c[29]}}, phase_c[29:0]};
		end
	end

	always_comb begin
		head.valid = valid_s3;
		head.mode  = mode_s3;
		head.re    = re_s3;
		head.im    = im_s3;
		head.quad  = quad_s3;
		head.x     = sspr_pkg::CORDIC_GAIN;
		head.y     = 32'sd0;
		head.z     = z_s3;
	end

endmodule

`default_nettype wire

// ----- rtl/sspr_cell.sv -----
// ---------------------------------------------------------------------------
// sspr_cell
// One rotation cell: a single CORDIC micro-rotation on the residual angle,
// passing the request and its vector on to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module sspr_cell (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic [sspr_pkg::CELL_IDX_W-1:0]    stage,
	input  wire sspr_pkg::cordic_t                  c_in,
	output sspr_pkg::cordic_t                       c_out
);

	logic signed [31:0] dx, dy, x_n, y_n, z_n, ang;

	logic               valid_s1, mode_s1;
	logic signed [31:0] re_s1, im_s1, x_s1, y_s1, z_s1;
	logic [1:0]         quad_s1;

	always_comb begin
		dx  = c_in.y >>> stage;
		dy  = c_in.x >>> stage;
		ang = sspr_pkg::atan_turn(stage);
		// Turn towards zero residual angle.
		if (!c_in.z[31]) begin
			x_n = c_in.x - dx;
			y_n = c_in.y + dy;
			z_n = c_in.z - ang;
		end else begin
			x_n = c_in.x + dx;
			y_n = c_in.y - dy;
			z_n = c_in.z + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= c_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= c_in.mode;
			re_s1   <= c_in.re;
			im_s1   <= c_in.im;
			quad_s1 <= c_in.quad;
			x_s1    <= x_n;
			y_s1    <= y_n;
			z_s1    <= z_n;
		end
	end

	always_comb begin
		c_out.valid = valid_s1;
		c_out.mode  = mode_s1;
		c_out.re    = re_s1;
		c_out.im    = im_s1;
		c_out.quad  = quad_s1;
		c_out.x     = x_s1;
		c_out.y     = y_s1;
		c_out.z     = z_s1;
	end

endmodule

`default_nettype wire

// ----- rtl/sspr_mix.sv -----
// ---------------------------------------------------------------------------
// sspr_mix
// Back end: applies the quadrant, multiplies the grid value by the unit
// phasor, rounds, scales drift results and saturates.
// ---------------------------------------------------------------------------
`default_nettype none

module sspr_mix (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire sspr_pkg::cordic_t tail,
	output sspr_pkg::result_t   res
);

	localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< 29;
	localparam logic signed [63:0] SAT_MAX    = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN    = -64'sd2147483648;

	logic signed [31:0] c_c, s_c;

	logic               valid_s1, mode_s1;
	logic signed [31:0] re_s1, im_s1, c_s1, s_s1;

	logic               valid_s2, mode_s2;
	logic signed [63:0] cr_s2, si_s2, sr_s2, ci_s2;

	logic               valid_s3, mode_s3;
	logic signed [63:0] re_sum_s3, im_sum_s3;

	logic signed [63:0] re_sh, im_sh;

	always_comb begin
		case (tail.quad)
			2'd0: begin
				c_c = tail.x;
				s_c = tail.y;
			end
			2'd1: begin
				c_c = -tail.y;
				s_c = tail.x;
			end
			2'd2: begin
				c_c = -tail.x;
				s_c = -tail.y;
			end
			default: begin
				c_c = tail.y;
				s_c = -tail.x;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= tail.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1   <= tail.mode;
			re_s1     <= tail.re;
			im_s1     <= tail.im;
			c_s1      <= c_c;
			s_s1      <= s_c;

			mode_s2   <= mode_s1;
			cr_s2     <= 64'(c_s1 * re_s1);
			si_s2     <= 64'(s_s1 * im_s1);
			sr_s2     <= 64'(s_s1 * re_s1);
			ci_s2     <= 64'(c_s1 * im_s1);

			mode_s3   <= mode_s2;
			re_sum_s3 <= cr_s2 - si_s2 + ROUND_HALF;
			im_sum_s3 <= sr_s2 + ci_s2 + ROUND_HALF;
		end
	end

	always_comb begin
		re_sh = re_sum_s3 >>> 30;
		im_sh = im_sum_s3 >>> 30;
		if (mode_s3) begin
			re_sh = re_sh >>> sspr_pkg::GRID_SHIFT;
			im_sh = im_sh >>> sspr_pkg::GRID_SHIFT;
		end

		res.valid = valid_s3;
		if (re_sh > SAT_MAX)
			res.re = 32'sh7fffffff;
		else if (re_sh < SAT_MIN)
			res.re = 32'sh80000000;
		else
			res.re = re_sh[31:0];
		if (im_sh > SAT_MAX)
			res.im = 32'sh7fffffff;
		else if (im_sh < SAT_MIN)
			res.im = 32'sh80000000;
		else
			res.im = im_sh[31:0];
	end

endmodule

`default_nettype wire

// ----- rtl/split_step_phase_rotation_unit.sv -----
// ---------------------------------------------------------------------------
// split_step_phase_rotation_unit
// Rotates a complex grid value by a kick or drift phase using a chain of
// CORDIC cells, with a registered output and a one-entry skid buffer.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  mode re_in im_in potential idx_i/j/k
//   out      source     out_valid/out_stall  re_out im_out
//   cfg      sink       cfg_valid/cfg_ready  cfg_index cfg_data
//
// One request per cycle is taken while in_stall is low.
// A request passes three front-end stages, one cell per rotation, three
// back-end stages and the output register.
// When the output stalls, the skid entry takes the next result and the whole
// pipe then holds; in_stall is the registered skid-full flag.
// Reset clears all valid flags and both coefficients.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module split_step_phase_rotation_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,

	input  wire logic                               in_valid,
	output wire logic                               in_stall,
	input  wire logic                               mode,
	input  wire logic signed [31:0]                 re_in,
	input  wire logic signed [31:0]                 im_in,
	input  wire logic signed [31:0]                 potential,
	input  wire logic [sspr_pkg::IDX_W-1:0]         idx_i,
	input  wire logic [sspr_pkg::IDX_W-1:0]         idx_j,
	input  wire logic [sspr_pkg::IDX_W-1:0]         idx_k,

	output wire logic                               out_valid,
	input  wire logic                               out_stall,
	output wire logic signed [31:0]                 re_out,
	output wire logic signed [31:0]                 im_out,

	input  wire logic                               cfg_valid,
	output wire logic                               cfg_ready,
	input  wire logic [sspr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [31:0]                        cfg_data
);

	logic [31:0]        kick_coeff_q, drift_coeff_q;
	logic               en, take;

	sspr_pkg::cordic_t  chain [0:sspr_pkg::CORDIC_STAGES];
	sspr_pkg::result_t  res;

	logic               out_valid_q, skid_valid_q;
	logic signed [31:0] out_re_q, out_im_q, skid_re_q, skid_im_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_coeff_q  <= 32'd0;
			drift_coeff_q <= 32'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sspr_pkg::REG_KICK:  kick_coeff_q  <= cfg_data;
				sspr_pkg::REG_DRIFT: drift_coeff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipe advances whenever the skid entry is free.
	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign take     = out_valid_q && !out_stall;

	sspr_phase u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.load        (in_valid),
		.mode        (mode),
		.re_in       (re_in),
		.im_in       (im_in),
		.potential   (potential),
		.idx_i       (idx_i),
		.idx_j       (idx_j),
		.idx_k       (idx_k),
		.kick_coeff  (kick_coeff_q),
		.drift_coeff (drift_coeff_q),
		.head        (chain[0])
	);

	for (genvar g = 0; g < sspr_pkg::CORDIC_STAGES; g++) begin : g_cell
		sspr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.stage  (sspr_pkg::CELL_IDX_W'(g)),
			.c_in   (chain[g]),
			.c_out  (chain[g+1])
		);
	end

	sspr_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tail   (chain[sspr_pkg::CORDIC_STAGES]),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (en) begin
			if (!out_valid_q || take)
				out_valid_q <= res.valid;
			else if (res.valid)
				skid_valid_q <= 1'b1;
		end else if (take) begin
			// Drain the skid entry into the output register.
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!out_valid_q || take) begin
				out_re_q <= res.re;
				out_im_q <= res.im;
			end else begin
				skid_re_q <= res.re;
				skid_im_q <= res.im;
			end
		end else if (take) begin
			out_re_q <= skid_re_q;
			out_im_q <= skid_im_q;
		end
	end

	assign out_valid = out_valid_q;
	assign re_out    = out_re_q;
	assign im_out    = out_im_q;

	`ASSERT_SAME(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
	`ASSERT_NEXT(a_skid_holds, skid_valid_q && out_stall, skid_valid_q, "skid lost while stalled")
	`ASSERT_SAME(a_skid_fill_on_stall, $rose(skid_valid_q), $past(out_valid_q && out_stall), "skid filled without stall")
	`ASSERT_NEXT(a_pipe_frozen, !en, $stable(res.valid), "pipe moved while held")

endmodule

`default_nettype wire

// ----- tb/tb_split_step_phase_rotation_unit.sv -----
// ---------------------------------------------------------------------------
// tb_split_step_phase_rotation_unit
// Drives grid cells in kick and drift mode through the rotation unit and
// checks each result against a bit-exact CORDIC predictor or a typed value.
// A directed table covers the field extremes, both modes, both registers and
// an unused register index. Random phases follow, each with its own pair of
// coefficients. Both handshakes idle at random outside one steady phase.
// ---------------------------------------------------------------------------
module tb_split_step_phase_rotation_unit;
	import sspr_pkg::*;

	localparam logic MODE_KICK  = 1'b0;
	localparam logic MODE_DRIFT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

	localparam logic signed [31:0] W_MIN   = 32'sh8000_0000;
	localparam logic signed [31:0] W_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

	localparam longint GAIN_Q30    = 64'sd652032874;
	localparam longint ROUND_HALF  = 64'sd536870912;
	localparam int     DRIFT_SHIFT = 3 * ($clog2(GRID + 1) - 1);
	localparam int     CYCLE_LIMIT = 100000;
	localparam int     PHASE_CELLS = 125;
	localparam int     DIR_ROWS    = 23;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic signed [31:0] pot;
		logic [IDX_W-1:0]   i;
		logic [IDX_W-1:0]   j;
		logic [IDX_W-1:0]   k;
	} cell_t;

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} rot_t;

	typedef enum logic {ROW_CELL, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		cell_t                req;
		logic                 typed;
		rot_t                 want;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [31:0]          reg_data;
	} row_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     mode      = 1'b0;
	logic signed [31:0]       re_in     = '0;
	logic signed [31:0]       im_in     = '0;
	logic signed [31:0]       potential = '0;
	logic [IDX_W-1:0]         idx_i     = '0;
	logic [IDX_W-1:0]         idx_j     = '0;
	logic [IDX_W-1:0]         idx_k     = '0;
	logic                     out_stall = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [31:0]              cfg_data  = '0;
	wire logic                in_stall;
	wire logic                out_valid;
	wire logic signed [31:0]  re_out;
	wire logic signed [31:0]  im_out;
	wire logic                cfg_ready;

	logic [31:0]  kick_turns  = '0;
	logic [31:0]  drift_turns = '0;
	rot_t         pending_rotations [$];
	rot_t         head_rotation;
	bit           steady      = 1'b0;
	int unsigned  mismatches  = 0;
	int unsigned  cycles      = 0;
	row_t         dir_rows [DIR_ROWS];
	logic [31:0]  kick_pick;
	logic [31:0]  drift_pick;

	// Arctangent of 2^-n in units of 2^-32 turn.
	longint atan_lut [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
		5, 3, 1, 1, 0
	};

	split_step_phase_rotation_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.re_in     (re_in),
		.im_in     (im_in),
		.potential (potential),
		.idx_i     (idx_i),
		.idx_j     (idx_j),
		.idx_k     (idx_k),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.re_out    (re_out),
		.im_out    (im_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int wrap_index(input logic [IDX_W-1:0] idx);
		int n;
		n = int'(idx);
		if (n >= GRID / 2)
			n = n - GRID;
		return n;
	endfunction

	function automatic logic signed [31:0] clamp_word(input longint v);
		if (v > 64'sd2147483647)
			return W_MAX;
		if (v < -64'sd2147483648)
			return W_MIN;
		return v[31:0];
	endfunction

	function automatic rot_t predict_rotation(input cell_t c);
		longint      prod, ksq, x, y, z, dx, dy, cv, sv, re, im;
		logic [63:0] neg;
		logic [31:0] phase, shifted, zw;
		logic [1:0]  quad;
		int          n;
		rot_t        r;
		if (c.mode == MODE_KICK) begin
			// Q16.48 product; keep bits 47..16 of its negation
			prod  = longint'({32'd0, kick_turns}) * longint'(c.pot);
			neg   = 64'(-prod);
			phase = neg[47:16];
		end else begin
			ksq = wrap_index(c.i) * wrap_index(c.i) + wrap_index(c.j) * wrap_index(c.j)
				+ wrap_index(c.k) * wrap_index(c.k);
			neg   = 64'd0 - {32'd0, drift_turns} * 64'(ksq);
			phase = neg[31:0];
		end
		// nearest quarter turn, residual in [-1/8, 1/8)
		shifted = phase + 32'h2000_0000;
		quad    = shifted[31:30];
		zw      = phase - {quad, 30'd0};
		z       = longint'(signed'(zw));
		x       = GAIN_Q30;
		y       = 0;
		for (n = 0; n < CORDIC_STAGES; n++) begin
			dx = y >>> n;
			dy = x >>> n;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_lut[n];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_lut[n];
			end
		end
		case (quad)
			2'd0: begin cv = x;  sv = y;  end
			2'd1: begin cv = -y; sv = x;  end
			2'd2: begin cv = -x; sv = -y; end
			default: begin cv = y; sv = -x; end
		endcase
		re = (cv * longint'(c.re) - sv * longint'(c.im) + ROUND_HALF) >>> 30;
		im = (sv * longint'(c.re) + cv * longint'(c.im) + ROUND_HALF) >>> 30;
		if (c.mode == MODE_DRIFT) begin
			re = re >>> DRIFT_SHIFT;
			im = im >>> DRIFT_SHIFT;
		end
		r.re = clamp_word(re);
		r.im = clamp_word(im);
		return r;
	endfunction

	function automatic cell_t make_cell(input logic m, input logic signed [31:0] r,
		input logic signed [31:0] q, input logic signed [31:0] p,
		input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] d);
		cell_t c;
		c.mode = m;
		c.re   = r;
		c.im   = q;
		c.pot  = p;
		c.i    = a;
		c.j    = b;
		c.k    = d;
		return c;
	endfunction

	function automatic row_t cell_row(input logic m, input logic signed [31:0] r,
		input logic signed [31:0] q, input logic signed [31:0] p,
		input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] d);
		row_t w;
		w       = '0;
		w.kind  = ROW_CELL;
		w.req   = make_cell(m, r, q, p, a, b, d);
		return w;
	endfunction

	function automatic row_t typed_row(input logic m, input logic signed [31:0] p,
		input logic [IDX_W-1:0] a, input logic signed [31:0] want_re,
		input logic signed [31:0] want_im);
		row_t w;
		w         = cell_row(m, 32'sd0, 32'sd0, p, a, a, a);
		w.typed   = 1'b1;
		w.want.re = want_re;
		w.want.im = want_im;
		return w;
	endfunction

	function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		row_t w;
		w          = '0;
		w.kind     = ROW_REG;
		w.reg_idx  = idx;
		w.reg_data = data;
		return w;
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(15))
			0: return W_MIN;
			1: return W_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		case ($urandom_range(11))
			0: return IDX_W'(0);
			1: return IDX_W'(GRID / 2 - 1);
			2: return IDX_W'(GRID / 2);
			3: return IDX_W'(GRID - 1);
			default: return IDX_W'($urandom_range(GRID - 1));
		endcase
	endfunction

	task automatic push_cell(input cell_t c, input logic typed, input rot_t want);
		while (!steady && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= c.mode;
		re_in     <= c.re;
		im_in     <= c.im;
		potential <= c.pot;
		idx_i     <= c.i;
		idx_j     <= c.j;
		idx_k     <= c.k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_rotations.push_back(typed ? want : predict_rotation(c));
	endtask

	// Hold off new requests until the pipe has emptied.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_rotations.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_KICK:  kick_turns  = data;
			REG_DRIFT: drift_turns = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic note_mismatch(input string field, input logic signed [31:0] want,
		input logic signed [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d", field, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_rotations.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with no request pending: re %0d im %0d", re_out, im_out);
				end else begin
					head_rotation = pending_rotations.pop_front();
					if (re_out !== head_rotation.re)
						note_mismatch("re_out", head_rotation.re, re_out);
					if (im_out !== head_rotation.im)
						note_mismatch("im_out", head_rotation.im, im_out);
				end
			end
			out_stall <= !steady && ($urandom_range(99) < 22);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		dir_rows = '{
			typed_row(MODE_KICK, W_MAX, 6'd0, 32'sd0, 32'sd0),
			typed_row(MODE_DRIFT, 32'sd0, 6'd63, 32'sd0, 32'sd0),
			cell_row(MODE_KICK, ONE_Q30, 32'sd0, 32'sd0, 6'd0, 6'd0, 6'd0),
			cell_row(MODE_KICK, W_MIN, W_MIN, W_MIN, 6'd0, 6'd0, 6'd0),
			cell_row(MODE_DRIFT, W_MAX, W_MIN, W_MAX, 6'd0, 6'd0, 6'd0),
			reg_row(REG_UNUSED, 32'hFFFF_FFFF),
			cell_row(MODE_KICK, W_MAX, W_MAX, W_MAX, 6'd63, 6'd63, 6'd63),
			reg_row(REG_KICK, 32'hFFFF_FFFF),
			reg_row(REG_DRIFT, 32'hFFFF_FFFF),
			cell_row(MODE_KICK, W_MIN, W_MIN, W_MIN, 6'd0, 6'd0, 6'd0),
			cell_row(MODE_KICK, W_MAX, W_MAX, W_MAX, 6'd0, 6'd0, 6'd0),
			cell_row(MODE_KICK, W_MIN, W_MAX, -32'sd1, 6'd0, 6'd0, 6'd0),
			cell_row(MODE_DRIFT, W_MIN, W_MIN, W_MIN, 6'd32, 6'd32, 6'd32),
			cell_row(MODE_DRIFT, W_MAX, W_MAX, W_MAX, 6'd31, 6'd31, 6'd31),
			cell_row(MODE_DRIFT, W_MIN, W_MAX, 32'sd0, 6'd63, 6'd0, 6'd33),
			// an eighth of a turn per 2^24 of potential, a quarter per kSq unit
			reg_row(REG_KICK, 32'h0020_0000),
			reg_row(REG_DRIFT, 32'h4000_0000),
			cell_row(MODE_KICK, W_MIN, W_MIN, 32'sh0100_0000, 6'd0, 6'd0, 6'd0),
			cell_row(MODE_KICK, W_MAX, W_MIN, 32'sh0300_0000, 6'd0, 6'd0, 6'd0),
			cell_row(MODE_KICK, ONE_Q30, 32'sd0, 32'sh0200_0000, 6'd0, 6'd0, 6'd0),
			cell_row(MODE_DRIFT, W_MIN, W_MIN, 32'sd0, 6'd1, 6'd0, 6'd0),
			cell_row(MODE_DRIFT, W_MAX, W_MAX, 32'sd0, 6'd1, 6'd1, 6'd0),
			cell_row(MODE_DRIFT, -32'sd1, 32'sd1, 32'sd0, 6'd0, 6'd0, 6'd1)
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_REG) begin
				drain_pipe();
				write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_data);
			end else begin
				push_cell(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].want);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			drain_pipe();
			case (ph)
				0: begin kick_pick = 32'd0;        drift_pick = 32'hFFFF_FFFF; end
				2: begin kick_pick = 32'hFFFF_FFFF; drift_pick = 32'd0;        end
				3: begin
					kick_pick  = $urandom_range(32'h0100_0000);
					drift_pick = $urandom_range(32'h0001_0000);
				end
				default: begin kick_pick = $urandom; drift_pick = $urandom; end
			endcase
			write_reg(REG_KICK, kick_pick);
			write_reg(REG_DRIFT, drift_pick);
			// one phase runs with no idling on either side
			steady = (ph == 3);
			repeat (PHASE_CELLS)
				push_cell(make_cell(1'($urandom), pick_word(), pick_word(), pick_word(),
					pick_index(), pick_index(), pick_index()), 1'b0, '0);
		end

		drain_pipe();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
